// ===== rtl/core/dnle_pkg.sv =====
`timescale 1ns / 1ps
// Package for the DNS name label encoder: status codes, action codes,
// controller states and the command/status structs between ctrl and datapath.
// No dependencies.
package dnle_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // What an accepted character does to the encoder.
    typedef enum logic [2:0] {
        ACT_DROP       = 3'd0,
        ACT_REARM      = 3'd1,
        ACT_STORE      = 3'd2,
        ACT_STORE_SEND = 3'd3,
        ACT_SEND       = 3'd4,
        ACT_FAIL       = 3'd5
    } t_act;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } t_state;

    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Length byte of the label plus the implied closing zero byte.
    localparam int NAME_OVERHEAD = 2;

    typedef struct packed {
        t_act act;       // action of the character on the input port
        logic out_free;  // output register empty or being taken
        logic rd_more;   // label bytes still to be read
        logic rd_vld;    // read data waits in the RAM output register
        logic last;      // waiting read data is the last byte of the label
    } t_sts;

    typedef struct packed {
        logic accept;    // input beat taken this cycle
        logic issue;     // read the next label byte
        logic consume;   // move read data into the output register
    } t_cmd;

endpackage

// ===== rtl/core/dnle_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dnle_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the label encoder: takes input beats and sequences the
// label read-out. Depends on dnle_pkg.
module dnle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dnle_pkg::t_sts i_sts,
    output dnle_pkg::t_cmd o_cmd
);

    import dnle_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.accept  = 1'b0;
        o_cmd.issue   = 1'b0;
        o_cmd.consume = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = i_sts.out_free;
                o_cmd.accept = i_in_valid && i_sts.out_free;
                if (o_cmd.accept &&
                    (i_sts.act == ACT_SEND || i_sts.act == ACT_STORE_SEND)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // keep one byte in flight in the RAM read register
                o_cmd.consume = i_sts.rd_vld && i_sts.out_free;
                o_cmd.issue   = i_sts.rd_more && (!i_sts.rd_vld || o_cmd.consume);
                if (o_cmd.consume && i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/dnle_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the label encoder: label RAM, name counters, decision logic
// and output register. Depends on dnle_pkg and dnle_ram.
module dnle_datapath #(
    parameter int MAX_NAME_BYTES  = 256,
    parameter int MAX_LABEL_BYTES = 63
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_character,
    input  logic           i_final_char,
    input  dnle_pkg::t_cmd i_cmd,
    output dnle_pkg::t_sts o_sts,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_run_end,
    output logic           o_name_end,
    output logic [1:0]     o_status
);

    import dnle_pkg::*;

    localparam int LCW = $clog2(MAX_LABEL_BYTES + 1);
    localparam int AW  = (MAX_LABEL_BYTES > 1) ? $clog2(MAX_LABEL_BYTES) : 1;
    localparam int EW  = $clog2(MAX_NAME_BYTES);
    localparam int SW  = $clog2(MAX_NAME_BYTES + MAX_LABEL_BYTES + NAME_OVERHEAD + 1);
    localparam logic [SW-1:0]  NAME_LIMIT  = SW'(MAX_NAME_BYTES);
    localparam logic [LCW-1:0] LABEL_LIMIT = LCW'(MAX_LABEL_BYTES);

    // name state
    logic [LCW-1:0] r_cnt, n_cnt;
    logic [EW-1:0]  r_emitted, n_emitted;
    logic           r_disc, n_disc;
    logic           r_prev_dot, n_prev_dot;
    // read-out state
    logic [LCW-1:0] r_len, n_len;
    logic           r_final, n_final;
    logic [LCW-1:0] r_issued, n_issued;
    logic [LCW-1:0] r_sent, n_sent;
    logic           r_rd_vld, n_rd_vld;
    // output register
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_byte, n_out_byte;
    logic           r_out_run_end, n_out_run_end;
    logic           r_out_name_end, n_out_name_end;
    t_status        r_out_status, n_out_status;

    t_act           act;
    t_status        fail_status;
    logic           is_dot;
    logic [7:0]     low_char;
    logic [LCW-1:0] send_len;
    logic [SW-1:0]  name_sum;
    logic           name_ovf;
    logic           out_free;
    logic           last;
    logic           ram_we;
    logic [7:0]     ram_rdata;

    dnle_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LABEL_BYTES)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (low_char),
        .i_re    (i_cmd.issue),
        .i_raddr (r_issued[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // classify the character on the input port
    always_comb begin
        is_dot   = (i_character == CH_DOT);
        low_char = (i_character >= CH_UPPER_A && i_character <= CH_UPPER_Z) ?
                   i_character + CASE_OFFSET : i_character;
        send_len = is_dot ? r_cnt : LCW'(r_cnt + 1'b1);
        name_sum = SW'(r_emitted) + SW'(send_len) + SW'(NAME_OVERHEAD);
        name_ovf = name_sum > NAME_LIMIT;
        fail_status = ST_INVALID;
        if (r_disc) begin
            act = i_final_char ? ACT_REARM : ACT_DROP;
        end else if (is_dot) begin
            if (r_cnt == '0) begin
                act = ACT_FAIL;
                if (i_final_char && r_emitted == '0 && !r_prev_dot) begin
                    fail_status = ST_EMPTY;
                end
            end else if (name_ovf) begin
                act = ACT_FAIL;
            end else begin
                act = ACT_SEND;
            end
        end else if (r_cnt >= LABEL_LIMIT) begin
            act = ACT_FAIL;
        end else if (i_final_char) begin
            act = name_ovf ? ACT_FAIL : ACT_STORE_SEND;
        end else begin
            act = ACT_STORE;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign last     = (LCW'(r_sent + 1'b1) == r_len);

    always_comb begin
        o_sts.act      = act;
        o_sts.out_free = out_free;
        o_sts.rd_more  = (r_issued != r_len);
        o_sts.rd_vld   = r_rd_vld;
        o_sts.last     = last;
    end

    always_comb begin
        n_cnt          = r_cnt;
        n_emitted      = r_emitted;
        n_disc         = r_disc;
        n_prev_dot     = r_prev_dot;
        n_len          = r_len;
        n_final        = r_final;
        n_issued       = r_issued;
        n_sent         = r_sent;
        n_rd_vld       = r_rd_vld;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_byte     = r_out_byte;
        n_out_run_end  = r_out_run_end;
        n_out_name_end = r_out_name_end;
        n_out_status   = r_out_status;
        ram_we         = 1'b0;

        if (i_cmd.accept) begin
            case (act)
                ACT_REARM: begin
                    n_cnt      = '0;
                    n_emitted  = '0;
                    n_disc     = 1'b0;
                    n_prev_dot = 1'b0;
                end
                ACT_STORE: begin
                    ram_we     = 1'b1;
                    n_cnt      = LCW'(r_cnt + 1'b1);
                    n_prev_dot = 1'b0;
                end
                ACT_STORE_SEND, ACT_SEND: begin
                    ram_we         = (act == ACT_STORE_SEND);
                    n_out_valid    = 1'b1;
                    n_out_byte     = 8'(send_len);
                    n_out_run_end  = 1'b0;
                    n_out_name_end = 1'b0;
                    n_out_status   = ST_OK;
                    n_len          = send_len;
                    n_final        = i_final_char;
                    n_issued       = '0;
                    n_sent         = '0;
                    n_cnt          = '0;
                    if (i_final_char) begin
                        n_emitted  = '0;
                        n_prev_dot = 1'b0;
                    end else begin
                        n_emitted  = EW'(r_emitted + EW'(send_len) + 1'b1);
                        n_prev_dot = 1'b1;
                    end
                end
                ACT_FAIL: begin
                    n_out_valid    = 1'b1;
                    n_out_byte     = 8'h00;
                    n_out_run_end  = 1'b1;
                    n_out_name_end = 1'b1;
                    n_out_status   = fail_status;
                    n_cnt          = '0;
                    n_emitted      = '0;
                    n_prev_dot     = 1'b0;
                    n_disc         = !i_final_char;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.issue) begin
            n_issued = LCW'(r_issued + 1'b1);
            n_rd_vld = 1'b1;
        end else if (i_cmd.consume) begin
            n_rd_vld = 1'b0;
        end

        if (i_cmd.consume) begin
            n_sent         = LCW'(r_sent + 1'b1);
            n_out_valid    = 1'b1;
            n_out_byte     = ram_rdata;
            n_out_run_end  = last;
            n_out_name_end = last && r_final;
            n_out_status   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_emitted   <= '0;
            r_disc      <= 1'b0;
            r_prev_dot  <= 1'b0;
            r_len       <= '0;
            r_final     <= 1'b0;
            r_issued    <= '0;
            r_sent      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_emitted   <= n_emitted;
            r_disc      <= n_disc;
            r_prev_dot  <= n_prev_dot;
            r_len       <= n_len;
            r_final     <= n_final;
            r_issued    <= n_issued;
            r_sent      <= n_sent;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte     <= n_out_byte;
        r_out_run_end  <= n_out_run_end;
        r_out_name_end <= n_out_name_end;
        r_out_status   <= n_out_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_end   = r_out_run_end;
    assign o_name_end  = r_out_name_end;
    assign o_status    = r_out_status;

`ifndef NO_ASSERTIONS
    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (r_issued != r_len))
        else $error("label read issued past label length");

    a_consume_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.consume |-> (r_rd_vld && out_free))
        else $error("label byte moved without read data or free output");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && (act == ACT_SEND || act == ACT_STORE_SEND || act == ACT_FAIL))
        |-> out_free)
        else $error("output register overwritten while occupied");

    a_label_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LABEL_LIMIT)
        else $error("label count beyond label limit");

    a_sent_le_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent <= r_issued)
        else $error("more label bytes sent than read");
`endif

endmodule

// ===== rtl/core/dns_name_label_encoder_core.sv =====
`timescale 1ns / 1ps
// Top level of the DNS name label encoder: controller plus datapath.
// Depends on dnle_pkg, dnle_ctrl, dnle_datapath and dnle_ram.
//
//  channel | direction | handshake                  | beat payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_character, i_final_char
//  out     | source    | o_out_valid / i_out_ready  | o_out_byte, o_run_end, o_name_end,
//          |           |                            | o_status
//
// A character that only joins the current label is stored in the label RAM.
// A dot or a final character puts the length byte into the output register at
// its accept edge; the label bytes follow from the single read port of the
// label RAM via its read register, one per cycle unless the output stalls,
// and the next input beat waits until the last of them is taken into the
// output register. Errors give one beat. Reset is synchronous and active low;
// the label RAM needs no clearing pass. An output stall also holds the input.
module dns_name_label_encoder_core #(
    parameter int MAX_NAME_BYTES  = 256,
    parameter int MAX_LABEL_BYTES = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel: one character of the dotted name per beat
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_character,
    input  logic       i_final_char,
    // output channel: one wire byte or status per beat
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_end,
    output logic       o_name_end,
    output logic [1:0] o_status
);

    import dnle_pkg::*;

    // command and status between the controller and the datapath
    t_cmd cmd;
    t_sts sts;

    // Controller: accept characters, then walk the label read-out.
    dnle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: fold case, buffer the label, check limits, drive the output.
    dnle_datapath #(
        .MAX_NAME_BYTES  (MAX_NAME_BYTES),
        .MAX_LABEL_BYTES (MAX_LABEL_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_character  (i_character),
        .i_final_char (i_final_char),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_name_end   (o_name_end),
        .o_status     (o_status)
    );

endmodule
